// File: hdl/aesm_pkg.sv
package aesm_pkg;

    localparam int RK_DEPTH = 15;
    localparam int RK_AW    = 4;
    localparam int RK_W     = 128;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY0   = 3'd0;
    localparam logic [2:0] CFG_KEY1   = 3'd1;
    localparam logic [2:0] CFG_KEY2   = 3'd2;
    localparam logic [2:0] CFG_KEY3   = 3'd3;
    localparam logic [2:0] CFG_MASKHI = 3'd4;
    localparam logic [2:0] CFG_MASKLO = 3'd5;

    localparam logic [63:0] MASK_HI_RST = 64'h0001020304050607;
    localparam logic [63:0] MASK_LO_RST = 64'h08090a0b0c0d0e0f;

    // Round key write from the expansion engine
    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [RK_W-1:0]  data;
    } aesm_kwr_t;

    // Entry 0 in the top byte
    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] ISBOX_TBL = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TBL[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return ISBOX_TBL[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 of a block sits in bits 127:120
    function automatic logic [127:0] enc_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0] t [16];
        logic [7:0] s [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            t[i] = sbox(st[127-8*i -: 8]);
        for (int i = 0; i < 16; i++)
            s[i] = t[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                s[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                s[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                s[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                s[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = s[i];
        return o ^ rk;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic         mix);
        logic [7:0] s [16];
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            s[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)] = st[127-8*i -: 8];
        for (int i = 0; i < 16; i++)
            s[i] = inv_sbox(s[i]) ^ rk[127-8*i -: 8];
        if (mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    a[j]  = s[4*c+j];
                    x2[j] = xt(a[j]);
                    x4[j] = xt(x2[j]);
                    x8[j] = xt(x4[j]);
                end
                // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
                for (int j = 0; j < 4; j++)
                    s[4*c+j] = (x8[j] ^ x4[j] ^ x2[j])
                             ^ (x8[(j+1)%4] ^ x2[(j+1)%4] ^ a[(j+1)%4])
                             ^ (x8[(j+2)%4] ^ x4[(j+2)%4] ^ a[(j+2)%4])
                             ^ (x8[(j+3)%4] ^ a[(j+3)%4]);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = s[i];
        return o;
    endfunction

endpackage

// File: hdl/aes256_block_cipher_masked_top.sv
// Masked AES block cipher. A block arrives on the s_ stream with the function
// in s_tuser (0 encrypt, 1 decrypt). Encrypt XORs the block with the 128-bit
// mask and runs the forward cipher; decrypt runs the inverse cipher and then
// XORs with the mask. The round keys live in a 15-entry x 128-bit RAM and are
// read one entry per cycle; the round unit does one full round per cycle. The
// next block is taken only after the previous one has left the round unit, a
// limit set by that single round unit and the one RAM read port. After reset
// and after every key register write the key schedule is rebuilt one 32-bit
// word per cycle; s_tready stays low meanwhile. A mask write reaches the next
// encrypt block and also a decrypt block still running, as decrypt applies the
// mask after its last round. The result sits in an output register, so a new
// block may be taken while the previous result waits.
module aes256_block_cipher_masked_top
    import aesm_pkg::*;
#(
    parameter int KEY_BITS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // data_hi[63:0], data_lo[127:64]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_hi[63:0], result_lo[127:64]
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam int NR = KEY_BITS / 32 + 6;
    localparam logic [RK_AW-1:0] LAST = RK_AW'(NR);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t           state_reg, state_next;
    logic [RK_AW-1:0] step_reg, step_next;
    logic             func_reg, func_next;
    logic [127:0]     st_reg, st_next;
    logic             mv_reg, mv_next;
    logic [127:0]     md_reg, md_next;

    logic [3:0][63:0] key_reg;
    logic [63:0]      mask_hi_reg, mask_lo_reg;
    logic [127:0]     mask, blk_in, rk, rnd_out;

    logic             key_wr, kbusy, accept, re, hold;
    logic [RK_AW-1:0] raddr;
    aesm_kwr_t        kwr;

    // Config registers
    assign key_wr = cfg_we && (cfg_addr == CFG_KEY0 || cfg_addr == CFG_KEY1
                               || cfg_addr == CFG_KEY2 || cfg_addr == CFG_KEY3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            mask_hi_reg <= MASK_HI_RST;
            mask_lo_reg <= MASK_LO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_KEY0:   key_reg[0]  <= cfg_wdata;
                CFG_KEY1:   key_reg[1]  <= cfg_wdata;
                CFG_KEY2:   key_reg[2]  <= cfg_wdata;
                CFG_KEY3:   key_reg[3]  <= cfg_wdata;
                CFG_MASKHI: mask_hi_reg <= cfg_wdata;
                CFG_MASKLO: mask_lo_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    aesm_keyexp #(.KEY_BITS(KEY_BITS)) u_keyexp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (key_wr),
        .key   (key_reg),
        .kwr   (kwr),
        .busy  (kbusy)
    );

    aesm_ram #(.WIDTH(RK_W), .DEPTH(RK_DEPTH)) u_rk_ram (
        .clk   (clk),
        .we    (kwr.we),
        .waddr (kwr.addr),
        .wdata (kwr.data),
        .re    (re),
        .raddr (raddr),
        .rdata (rk)
    );

    // Block byte 0 is the top byte of data_hi
    assign mask   = {mask_hi_reg, mask_lo_reg};
    assign blk_in = {s_tdata[63:0], s_tdata[127:64]};

    assign s_tready = (state_reg == ST_IDLE) && !kbusy && !key_wr;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        rnd_out = func_reg ? dec_round(st_reg, rk, step_reg != LAST)
                           : enc_round(st_reg, rk, step_reg == LAST);
        if (step_reg == '0)
            rnd_out = st_reg ^ rk;
    end

    // Last step waits while the output register still holds a result
    assign hold = (state_reg == ST_RUN) && (step_reg == LAST) && mv_reg && !m_tready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        func_next  = func_reg;
        st_next    = st_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        re         = 1'b0;
        raddr      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    re         = 1'b1;
                    raddr      = s_tuser ? LAST : '0;
                    func_next  = s_tuser;
                    st_next    = s_tuser ? blk_in : (blk_in ^ mask);
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg != LAST)
                begin
                    re        = 1'b1;
                    raddr     = func_reg ? (LAST - step_reg - 1'b1) : (step_reg + 1'b1);
                    st_next   = rnd_out;
                    step_next = step_reg + 1'b1;
                end
                else if (!hold)
                begin
                    mv_next    = 1'b1;
                    md_next    = func_reg ? (rnd_out ^ mask) : rnd_out;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            mv_reg    <= 1'b0;
            func_reg  <= 1'b0;
            st_reg    <= '0;
            md_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mv_reg    <= mv_next;
            func_reg  <= func_next;
            st_reg    <= st_next;
            md_reg    <= md_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {md_reg[63:0], md_reg[127:64]};

    a_no_accept_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !kbusy)
        else $error("block taken during key expansion");

    a_no_kwrite_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        kwr.we |-> state_reg == ST_IDLE)
        else $error("round key written while a block runs");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("transfer did not start a run");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg <= LAST)
        else $error("round counter out of range");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !m_tready) |=> mv_reg && $stable(md_reg))
        else $error("pending result overwritten");

endmodule

// File: hdl/aesm_ram.sv
module aesm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: hdl/aesm_keyexp.sv
module aesm_keyexp
    import aesm_pkg::*;
#(
    parameter int KEY_BITS = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [3:0][63:0] key,
    output aesm_kwr_t       kwr,
    output logic            busy
);

    localparam int NK    = KEY_BITS / 32;
    localparam int NR    = NK + 6;
    localparam int TOTAL = 4 * (NR + 1);
    localparam int WIW   = $clog2(TOTAL);

    logic [WIW-1:0] wi_reg;
    logic [2:0]     wmod_reg;
    logic [7:0]     rcon_reg;
    logic           busy_reg;
    logic [31:0]    win_reg [NK];
    logic [95:0]    row_reg;

    logic [63:0] kpair;
    logic [31:0] kw, tw, tsub, nw;
    logic        from_key;

    always_comb
    begin
        kpair    = key[wi_reg[2:1]];
        kw       = wi_reg[0] ? kpair[31:0] : kpair[63:32];
        tw       = win_reg[NK-1];
        from_key = (wi_reg < WIW'(NK));
        tsub     = tw;
        if (wmod_reg == 3'd0)
            tsub = {sbox(tw[23:16]) ^ rcon_reg, sbox(tw[15:8]), sbox(tw[7:0]),
                    sbox(tw[31:24])};
        else if (NK > 6 && wmod_reg == 3'd4)
            tsub = {sbox(tw[31:24]), sbox(tw[23:16]), sbox(tw[15:8]), sbox(tw[7:0])};
        nw = from_key ? kw : (tsub ^ win_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            wi_reg   <= '0;
            wmod_reg <= '0;
            rcon_reg <= 8'h01;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            wi_reg   <= '0;
            wmod_reg <= '0;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            wi_reg   <= wi_reg + 1'b1;
            wmod_reg <= (wmod_reg == 3'(NK - 1)) ? 3'd0 : wmod_reg + 1'b1;
            if (!from_key && wmod_reg == 3'd0)
                rcon_reg <= xt(rcon_reg);
            if (wi_reg == WIW'(TOTAL - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            for (int k = 0; k < NK - 1; k++)
                win_reg[k] <= win_reg[k+1];
            win_reg[NK-1] <= nw;
            row_reg       <= {row_reg[63:0], nw};
        end
    end

    assign kwr.we   = busy_reg && !start && (wi_reg[1:0] == 2'd3);
    assign kwr.addr = RK_AW'(wi_reg >> 2);
    assign kwr.data = {row_reg, nw};
    assign busy     = busy_reg;

endmodule

// File: dv/aesm_checker.sv
`timescale 1ns / 1ps

package aesm_tb_pkg;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } aesm_op_e;

    // Indexes past the last register; writes to them are dropped
    localparam logic [2:0] CFG_SPARE6 = 3'd6;
    localparam logic [2:0] CFG_SPARE7 = 3'd7;

endpackage

module aesm_checker
    import aesm_pkg::*;
    import aesm_tb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_t;

    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_reg [4];
    logic [63:0]  mask_hi_q;
    logic [63:0]  mask_lo_q;
    logic [127:0] sched [15];
    block_t       expected_blocks [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // S-box from the multiplicative inverse plus the affine map
    initial
    begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            for (int e = 0; e < 254; e++)
                inv = gf_mul(inv, x[7:0]);
            if (x == 0)
                inv = 8'h00;
            s = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = x[7:0];
        end
    end

    function automatic void expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t = {fwd_sub[t[23:16]] ^ rcon, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
                     fwd_sub[t[31:24]]};
                rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
            end
            else if (i % 8 == 4)
                t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
            w[i] = t ^ w[i-8];
        end
        for (int r = 0; r < 15; r++)
            sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    // Byte 0 in bits 127:120; byte (row, col) at index row + 4*col
    function automatic logic [127:0] aes_forward(input logic [127:0] blk);
        logic [7:0]   t [16];
        logic [7:0]   s [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] st;
        st = blk ^ sched[0];
        for (int r = 1; r <= 14; r++)
        begin
            for (int i = 0; i < 16; i++)
                t[i] = fwd_sub[st[127-8*i -: 8]];
            for (int i = 0; i < 16; i++)
                s[i] = t[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)];
            if (r != 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3);
                    s[4*c+3] = gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2);
                end
            end
            for (int i = 0; i < 16; i++)
                st[127-8*i -: 8] = s[i];
            st ^= sched[r];
        end
        return st;
    endfunction

    function automatic logic [127:0] aes_inverse(input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] st;
        st = blk ^ sched[14];
        for (int r = 13; r >= 0; r--)
        begin
            for (int i = 0; i < 16; i++)
                s[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)] = st[127-8*i -: 8];
            for (int i = 0; i < 16; i++)
                s[i] = inv_sub[s[i]] ^ sched[r][127-8*i -: 8];
            if (r != 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                    s[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                    s[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                    s[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
                end
            end
            for (int i = 0; i < 16; i++)
                st[127-8*i -: 8] = s[i];
        end
        return st;
    endfunction

    function automatic block_t masked_cipher(input aesm_op_e op, input block_t din);
        logic [127:0] mask;
        mask = {mask_hi_q, mask_lo_q};
        if (op == OP_ENC)
            return aes_forward({din.hi, din.lo} ^ mask);
        return aes_inverse({din.hi, din.lo}) ^ mask;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        block_t got;
        block_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] = 64'h0;
            mask_hi_q = MASK_HI_RST;
            mask_lo_q = MASK_LO_RST;
            expand_schedule();
            expected_blocks.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3:
                    begin
                        key_reg[cfg_addr[1:0]] = cfg_wdata;
                        expand_schedule();
                    end
                    CFG_MASKHI: mask_hi_q = cfg_wdata;
                    CFG_MASKLO: mask_lo_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_blocks.push_back(masked_cipher(aesm_op_e'(s_tuser),
                                                        '{hi: s_tdata[63:0],
                                                          lo: s_tdata[127:64]}));
            if (m_tvalid && m_tready)
            begin
                got = '{hi: m_tdata[63:0], lo: m_tdata[127:64]};
                if (expected_blocks.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (got.hi !== want.hi)
                        $error("result_hi: expected %h, actual %h", want.hi, got.hi);
                    if (got.lo !== want.lo)
                        $error("result_lo: expected %h, actual %h", want.lo, got.lo);
                    if (got !== want)
                        errors <= errors + 1;
                end
            end
            pending <= expected_blocks.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the masked AES-256 block. The checker next to the
// dut predicts every block and counts mismatches; this module drives and reports.
module tb_top;
    import aesm_pkg::*;
    import aesm_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // data_hi[63:0], data_lo[127:64]
    logic         s_tuser;   // func
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // result_hi[63:0], result_lo[127:64]
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [63:0]  cfg_wdata;

    int errors;
    int pending;
    int cycles = 0;
    bit no_gaps;         // phases run back-to-back on both sides
    int results_taken;

    aes256_block_cipher_masked_top dut (.*);

    aesm_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: far above the slowest legal run (key rebuilds, gaps, stalls)
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side. Random backpressure per transfer, plus one long hold
    // while the sender keeps pushing so the output register and the input
    // side both back up.
    initial
    begin
        int gap;
        bit held;
        m_tready      = 1'b0;
        results_taken = 0;
        held          = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (!held && results_taken == 150)
            begin
                held = 1'b1;
                gap  = 400;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
        end
    end

    task automatic send_block(input aesm_op_e op, input logic [63:0] hi,
                              input logic [63:0] lo);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {lo, hi};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and let every accepted block come back before touching
    // the registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setup(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] mh, input logic [63:0] ml);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_MASKHI, mh);
        write_reg(CFG_MASKLO, ml);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_blocks(input int count);
        for (int n = 0; n < count; n++)
            send_block(aesm_op_e'($urandom_range(0, 1)), rand_word(), rand_word());
    endtask

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ENC;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_KEY0;
        cfg_wdata = '0;
        no_gaps   = 1'b0;
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset key and mask: extremes of the block in both directions
        send_block(OP_ENC, 64'h0, 64'h0);
        send_block(OP_DEC, 64'h0, 64'h0);
        send_block(OP_ENC, '1, '1);
        send_block(OP_DEC, '1, '1);
        send_block(OP_ENC, 64'h8000000000000000, 64'h0000000000000001);
        send_block(OP_DEC, 64'h0000000000000001, 64'h8000000000000000);
        drain();

        // Published AES-256 vector with the mask cleared
        load_setup(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, 64'h18191a1b1c1d1e1f, 64'h0, 64'h0);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();

        // All-ones key and mask; spare indexes must be ignored
        load_setup('1, '1, '1, '1, '1, '1);
        write_reg(CFG_SPARE6, 64'h0);
        write_reg(CFG_SPARE7, 64'h0);
        send_block(OP_ENC, 64'h0, 64'h0);
        send_block(OP_DEC, 64'h0, 64'h0);
        send_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(OP_DEC, '1, '1);
        drain();

        // Mask-only change takes effect on the next block
        write_reg(CFG_MASKHI, 64'h5555aaaa5555aaaa);
        send_block(OP_ENC, 64'h0, 64'h0);
        send_block(OP_DEC, 64'h0, 64'h0);
        drain();

        // Random phases; some run without any gaps
        for (int ph = 0; ph < 6; ph++)
        begin
            load_setup(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word());
            no_gaps = (ph % 3 == 2);
            random_blocks(310);
            drain();
        end

        // Single key word rewrite between phases
        no_gaps = 1'b0;
        write_reg(CFG_KEY2, 64'h0);
        random_blocks(20);
        drain();

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
